>>> hw/rtl/sfrs16_pkg.sv
// ----------------------------------------------------------------------------
// sfrs16_pkg
// Shared types and constants for the serial frame receiver with 16-bit sum.
// ----------------------------------------------------------------------------
package sfrs16_pkg;

    localparam int POS_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 16;
    localparam int TDATA_W  = 72;

    localparam logic [POS_W-1:0] POS_FLAG = 4'd0;
    localparam logic [POS_W-1:0] POS_SRC  = 4'd1;
    localparam logic [POS_W-1:0] POS_DST  = 4'd2;
    localparam logic [POS_W-1:0] POS_CMD  = 4'd3;
    localparam logic [POS_W-1:0] POS_SER  = 4'd4;
    localparam logic [POS_W-1:0] POS_LEN  = 4'd5;
    localparam logic [POS_W-1:0] POS_DATA = 4'd6;
    localparam logic [POS_W-1:0] POS_SUMH = 4'd7;
    localparam logic [POS_W-1:0] POS_SUML = 4'd8;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] data_index;
        logic              frame_done;
        logic              frame_ok;
        logic [BYTE_W-1:0] flag_field;
        logic [BYTE_W-1:0] source_address;
        logic [BYTE_W-1:0] dest_address;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] serial_number;
        logic [BYTE_W-1:0] payload_length;
    } result_t;

endpackage

>>> hw/rtl/serial_frame_receiver_sum16_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum16_unit
// Length-prefixed frame parser with 16-bit additive checksum, one result
// transfer per received byte.
// ----------------------------------------------------------------------------
// output: a two-entry buffer (result register plus skid register) registers
//   each accepted byte's result and keeps s_tready high while one result waits
// throughput: one byte per cycle until the skid register fills
// reset: synchronous aresetn returns the parser to the flag byte, clears the
//   sum and empties the output buffer
module serial_frame_receiver_sum16_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // data_byte, data_index, frame_ok, flag_field, source_address,
    // dest_address, command_code, serial_number, payload_length, zero pad
    output logic [sfrs16_pkg::TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,  // data_valid
    output logic                              m_tlast   // frame_done
);

    sfrs16_pkg::result_t res;
    sfrs16_pkg::result_t out_reg,  out_next;
    sfrs16_pkg::result_t skid_reg, skid_next;
    logic                out_valid_reg,  out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                in_accept;
    logic                out_free;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    sfrs16_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (in_accept),
        .rx_byte     (s_tdata),
        .result      (res)
    );

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_accept) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_accept) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.data_valid;
    assign m_tlast  = out_reg.frame_done;
    assign m_tdata  = {7'd0,
                       out_reg.payload_length,
                       out_reg.serial_number,
                       out_reg.command_code,
                       out_reg.dest_address,
                       out_reg.source_address,
                       out_reg.flag_field,
                       out_reg.frame_ok,
                       out_reg.data_index,
                       out_reg.data_byte};

endmodule

>>> hw/rtl/sfrs16_parser.sv
// ----------------------------------------------------------------------------
// sfrs16_parser
// Frame parse state, header capture and running checksum; gives the result
// for the byte presented this cycle and advances on each accepted byte.
// ----------------------------------------------------------------------------
module sfrs16_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            byte_accept,
    input  logic [sfrs16_pkg::BYTE_W-1:0]   rx_byte,
    output sfrs16_pkg::result_t             result
);

    logic [sfrs16_pkg::POS_W-1:0]  pos_reg,     pos_next;
    logic [sfrs16_pkg::BYTE_W-1:0] count_reg,   count_next;
    logic [sfrs16_pkg::BYTE_W-1:0] flag_reg,    flag_next;
    logic [sfrs16_pkg::BYTE_W-1:0] src_reg,     src_next;
    logic [sfrs16_pkg::BYTE_W-1:0] dst_reg,     dst_next;
    logic [sfrs16_pkg::BYTE_W-1:0] cmd_reg,     cmd_next;
    logic [sfrs16_pkg::BYTE_W-1:0] ser_reg,     ser_next;
    logic [sfrs16_pkg::BYTE_W-1:0] len_reg,     len_next;
    logic [sfrs16_pkg::SUM_W-1:0]  sum_reg,     sum_next;
    logic [sfrs16_pkg::BYTE_W-1:0] sumh_reg,    sumh_next;
    logic [sfrs16_pkg::SUM_W-1:0]  sum_added;
    logic [sfrs16_pkg::BYTE_W-1:0] count_inc;

    assign sum_added = sum_reg + {{(sfrs16_pkg::SUM_W-sfrs16_pkg::BYTE_W){1'b0}}, rx_byte};
    assign count_inc = count_reg + 8'd1;

    always_comb begin
        pos_next   = pos_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        cmd_next   = cmd_reg;
        ser_next   = ser_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        sumh_next  = sumh_reg;
        result     = '0;
        case (pos_reg)
            sfrs16_pkg::POS_SRC: begin
                src_next = rx_byte;
                sum_next = sum_added;
                pos_next = sfrs16_pkg::POS_DST;
            end
            sfrs16_pkg::POS_DST: begin
                dst_next = rx_byte;
                sum_next = sum_added;
                pos_next = sfrs16_pkg::POS_CMD;
            end
            sfrs16_pkg::POS_CMD: begin
                cmd_next = rx_byte;
                sum_next = sum_added;
                pos_next = sfrs16_pkg::POS_SER;
            end
            sfrs16_pkg::POS_SER: begin
                ser_next = rx_byte;
                sum_next = sum_added;
                pos_next = sfrs16_pkg::POS_LEN;
            end
            sfrs16_pkg::POS_LEN: begin
                len_next = rx_byte;
                sum_next = sum_added;
                pos_next = (rx_byte == 8'd0) ? sfrs16_pkg::POS_SUMH : sfrs16_pkg::POS_DATA;
            end
            sfrs16_pkg::POS_DATA: begin
                sum_next          = sum_added;
                result.data_valid = 1'b1;
                result.data_byte  = rx_byte;
                result.data_index = count_reg;
                count_next        = count_inc;
                if (count_inc >= len_reg) begin
                    pos_next = sfrs16_pkg::POS_SUMH;
                end
            end
            sfrs16_pkg::POS_SUMH: begin
                sumh_next = rx_byte;
                pos_next  = sfrs16_pkg::POS_SUML;
            end
            sfrs16_pkg::POS_SUML: begin
                result.frame_done     = 1'b1;
                result.frame_ok       = (sum_reg == {sumh_reg, rx_byte});
                result.flag_field     = flag_reg;
                result.source_address = src_reg;
                result.dest_address   = dst_reg;
                result.command_code   = cmd_reg;
                result.serial_number  = ser_reg;
                result.payload_length = len_reg;
                pos_next              = sfrs16_pkg::POS_FLAG;
                count_next            = '0;
            end
            default: begin
                flag_next  = rx_byte;
                sum_next   = '0;
                count_next = '0;
                pos_next   = sfrs16_pkg::POS_SRC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= sfrs16_pkg::POS_FLAG;
            count_reg <= '0;
            flag_reg  <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            cmd_reg   <= '0;
            ser_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            sumh_reg  <= '0;
        end else if (byte_accept) begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            cmd_reg   <= cmd_next;
            ser_reg   <= ser_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            sumh_reg  <= sumh_next;
        end
    end

endmodule

>>> hw/rtl/sfrs16_checker.sv
// ----------------------------------------------------------------------------
// sfrs16_checker
// Port-level checks for the serial frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfrs16_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sfrs16_pkg::TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // a byte is either payload or frame end, never both
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tlast))
        else $error("data and frame end together");

    // header fields and status are zero unless the frame ends here
    a_hdr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[64:16] == 49'd0)
        else $error("header fields set outside frame end");

    // payload byte and index are zero unless this was a data byte
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)
        else $error("payload fields set outside data byte");

    // output buffer is empty and ready after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not cleared by reset");

endmodule

bind serial_frame_receiver_sum16_unit sfrs16_checker u_sfrs16_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
